// ----- hdl/kdm_pkg.sv -----
// Shared types and constants for the k-differences matcher.
// Used by kdm_cell, kdm_chain and k_differences_match; depends on nothing.
package kdm_pkg;

  localparam int unsigned MaxPattern = 64;
  localparam int unsigned MaxText    = 1048576;
  localparam int unsigned IdxW       = $clog2(MaxPattern);
  localparam int unsigned DistW      = $clog2(MaxPattern + 1);
  localparam int unsigned SymW       = 8;
  localparam int unsigned PosW       = $clog2(MaxText + 1);

  typedef enum logic {
    ReqPattern = 1'b0,
    ReqText    = 1'b1
  } kdm_req_e;

  // One text byte travelling down the row of cells. left is the new value
  // of the row above at this column, diag its value at the previous column.
  typedef struct packed {
    logic             v;
    logic             first;
    logic [SymW-1:0]  sym;
    logic [DistW-1:0] left;
    logic [DistW-1:0] diag;
    logic [DistW-1:0] res;
  } kdm_token_t;

  // Pattern load control broadcast to every cell.
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    logic [SymW-1:0] sym;
    logic            reload;
  } kdm_pwr_t;

endpackage

// ----- hdl/kdm_cell.sv -----
// One row of the edit-distance column: holds a pattern byte and its distance.
// Depends on kdm_pkg.
module kdm_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic [kdm_pkg::IdxW-1:0]  idx_i,
  input  logic [kdm_pkg::DistW-1:0] m_i,
  input  kdm_pkg::kdm_pwr_t       pwr_i,
  input  kdm_pkg::kdm_token_t     tok_i,
  output kdm_pkg::kdm_token_t     tok_o
);

  logic [kdm_pkg::SymW-1:0]  pat_q;
  logic [kdm_pkg::DistW-1:0] d_q;
  logic                      v_q;
  kdm_pkg::kdm_token_t       pay_q;

  logic [kdm_pkg::DistW-1:0] row;
  logic [kdm_pkg::DistW-1:0] up;
  logic [kdm_pkg::DistW-1:0] sub;
  logic [kdm_pkg::DistW-1:0] ins;
  logic [kdm_pkg::DistW-1:0] del;
  logic [kdm_pkg::DistW-1:0] cur;

  always_comb begin
    row = kdm_pkg::DistW'(idx_i) + kdm_pkg::DistW'(1);
    // a new scan sees the reloaded column
    up  = tok_i.first ? row : d_q;
    sub = tok_i.diag + kdm_pkg::DistW'(pat_q != tok_i.sym);
    ins = up + kdm_pkg::DistW'(1);
    del = tok_i.left + kdm_pkg::DistW'(1);
    cur = (sub < ins) ? sub : ins;
    if (del < cur) begin
      cur = del;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pwr_i.we && (pwr_i.addr == idx_i)) begin
      pat_q <= pwr_i.sym;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pwr_i.reload) begin
      d_q <= row;
    end else if (en_i && tok_i.v) begin
      d_q <= cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= tok_i.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && tok_i.v) begin
      pay_q.v     <= 1'b1;
      pay_q.first <= tok_i.first;
      pay_q.sym   <= tok_i.sym;
      pay_q.left  <= cur;
      pay_q.diag  <= up;
      // the row at the pattern length carries the final distance
      pay_q.res   <= (row == m_i) ? cur : tok_i.res;
    end
  end

  always_comb begin
    tok_o   = pay_q;
    tok_o.v = v_q;
  end

endmodule

// ----- hdl/kdm_chain.sv -----
// Row of MaxPattern cells, one per pattern position, stepping in lockstep.
// Depends on kdm_pkg and kdm_cell.
module kdm_chain (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic [kdm_pkg::DistW-1:0] m_i,
  input  kdm_pkg::kdm_pwr_t       pwr_i,
  input  kdm_pkg::kdm_token_t     tok_i,
  output kdm_pkg::kdm_token_t     tok_o,
  output logic                    busy_o
);

  kdm_pkg::kdm_token_t             toks [kdm_pkg::MaxPattern+1];
  logic [kdm_pkg::MaxPattern-1:0]  vld;

  assign toks[0] = tok_i;

  for (genvar g = 0; g < kdm_pkg::MaxPattern; g++) begin : g_cell
    kdm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .idx_i  (kdm_pkg::IdxW'(g)),
      .m_i    (m_i),
      .pwr_i  (pwr_i),
      .tok_i  (toks[g]),
      .tok_o  (toks[g+1])
    );
    assign vld[g] = toks[g+1].v;
  end

  assign tok_o  = toks[kdm_pkg::MaxPattern];
  assign busy_o = |vld;

endmodule

// ----- hdl/k_differences_match.sv -----
// Approximate pattern search, at most max_errors edit differences.
// Depends on kdm_pkg and kdm_chain.
//
// Load the pattern first (tuser[0]=0, one byte per request, tuser[1]=1 on
// the first byte), then stream text bytes (tuser[0]=1, tuser[1]=1 starts a
// new scan). Each text byte gives one result: match in tuser, end position
// and running match count in tdata. Text bytes enter a row of 64 cells, one
// per pattern position, and pass through 64 cell stages plus the output
// register on the way to the result; a new text byte is taken every cycle
// while results are drained. A pattern byte is taken only once the cell
// row is empty, then one per cycle, and produces no result.
module k_differences_match (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,      // max_errors
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] symbol
  input  logic [1:0]  s_axis_tuser_i,  // [0] req_type, [1] first
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // [20:0] end_position, [41:21] match_count
  output logic [0:0]  m_axis_tuser_o   // [0] match
);

  localparam int unsigned DistW = kdm_pkg::DistW;
  localparam int unsigned PosW  = kdm_pkg::PosW;

  logic [DistW-1:0] maxerr_q;
  logic [DistW-1:0] plen_q;
  logic [DistW-1:0] plen_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  cnt_q, cnt_d, cnt_base;
  logic             match_q, hit;
  logic             m_valid_q;

  logic                adv;
  logic                busy;
  logic                s_acc;
  logic                pat_acc;
  logic                is_text;
  logic                first;
  kdm_pkg::kdm_pwr_t   pwr;
  kdm_pkg::kdm_token_t head;
  kdm_pkg::kdm_token_t tail;

  assign is_text = (kdm_pkg::kdm_req_e'(s_axis_tuser_i[0]) == kdm_pkg::ReqText);
  assign first   = s_axis_tuser_i[1];

  // the row moves whenever the output register can take what leaves it
  assign adv             = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = is_text ? adv : !busy;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign pat_acc         = s_acc && !is_text;
  assign cfg_ready_o     = 1'b1;

  always_comb begin
    head       = '0;
    head.v     = s_acc && is_text;
    head.first = first;
    head.sym   = s_axis_tdata_i;
  end

  always_comb begin
    pwr.reload = pat_acc;
    pwr.sym    = s_axis_tdata_i;
    pwr.we     = pat_acc && (first || (plen_q < DistW'(kdm_pkg::MaxPattern)));
    pwr.addr   = first ? '0 : plen_q[kdm_pkg::IdxW-1:0];
    if (first) begin
      plen_d = DistW'(1);
    end else if (plen_q < DistW'(kdm_pkg::MaxPattern)) begin
      plen_d = plen_q + DistW'(1);
    end else begin
      plen_d = plen_q;
    end
  end

  kdm_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .m_i    (plen_q),
    .pwr_i  (pwr),
    .tok_i  (head),
    .tok_o  (tail),
    .busy_o (busy)
  );

  always_comb begin
    hit = (maxerr_q < plen_q) && (tail.res <= maxerr_q);
    if (tail.first) begin
      pos_d = PosW'(1);
    end else if (pos_q < PosW'(kdm_pkg::MaxText)) begin
      pos_d = pos_q + PosW'(1);
    end else begin
      pos_d = pos_q;
    end
    cnt_base = tail.first ? '0 : cnt_q;
    if (hit && (cnt_base < PosW'(kdm_pkg::MaxText))) begin
      cnt_d = cnt_base + PosW'(1);
    end else begin
      cnt_d = cnt_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxerr_q  <= DistW'(1);
      plen_q    <= '0;
      pos_q     <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        maxerr_q <= cfg_data_i;
      end
      if (pat_acc) begin
        plen_q <= plen_d;
      end
      if (adv) begin
        m_valid_q <= tail.v;
      end
      if (adv && tail.v) begin
        pos_q <= pos_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tail.v) begin
      match_q <= hit;
    end
  end

  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = {6'b0, cnt_q, pos_q};
  assign m_axis_tuser_o[0] = match_q;

  a_count_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (cnt_q <= pos_q))
    else $error("match count passed end position");

  a_match_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && match_q) |-> (cnt_q != '0))
    else $error("match reported with zero count");

  a_plen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= DistW'(kdm_pkg::MaxPattern))
    else $error("pattern length out of range");

  a_pattern_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat_acc |=> !busy)
    else $error("pattern loaded while text in flight");

endmodule
